// File: rtl/dmc_pkg.sv
`default_nettype none

package dmc_pkg;

	// Default geometry: eight lines of sixteen bytes, 20-bit byte address,
	// four-byte accesses.
	localparam int unsigned DefNumLines    = 8;
	localparam int unsigned DefBlockBytes  = 16;
	localparam int unsigned DefAddrBits    = 20;
	localparam int unsigned DefAccessBytes = 4;

	// Byte lanes carried by every request and response.
	localparam int unsigned LANES  = 4;
	localparam int unsigned BYTE_W = 8;

	// Access kinds carried in the cmd field of a request.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

// File: rtl/dmc_if.sv
`default_nettype none

// Request channel: one read or write access.
interface dmc_req_if
	import dmc_pkg::*;
#(
	parameter int unsigned ADDR_BITS = DefAddrBits
) ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [ADDR_BITS-1:0] address;
	byte_t                wdata0;
	byte_t                wdata1;
	byte_t                wdata2;
	byte_t                wdata3;

	modport source (
		output valid, cmd, address, wdata0, wdata1, wdata2, wdata3,
		input  ready
	);
	modport sink (
		input  valid, cmd, address, wdata0, wdata1, wdata2, wdata3,
		output ready
	);
endinterface

// Response channel: hit flag, address fields and four data bytes.
interface dmc_rsp_if
	import dmc_pkg::*;
#(
	parameter int unsigned ADDR_BITS   = DefAddrBits,
	parameter int unsigned NUM_LINES   = DefNumLines,
	parameter int unsigned BLOCK_BYTES = DefBlockBytes
) ();
	localparam int unsigned LINE_BITS = $clog2(NUM_LINES);
	localparam int unsigned OFF_BITS  = $clog2(BLOCK_BYTES);
	localparam int unsigned TAG_BITS  = ADDR_BITS - LINE_BITS - OFF_BITS;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [TAG_BITS-1:0]  tag_out;
	logic [LINE_BITS-1:0] line_out;
	logic [OFF_BITS-1:0]  offset_out;
	byte_t                byte0;
	byte_t                byte1;
	byte_t                byte2;
	byte_t                byte3;

	modport source (
		output valid, hit, tag_out, line_out, offset_out, byte0, byte1, byte2, byte3,
		input  ready
	);
	modport sink (
		input  valid, hit, tag_out, line_out, offset_out, byte0, byte1, byte2, byte3,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/direct_mapped_writeback_cache.sv
// Channel | Direction | Handshake     | Carries
// req     | in        | valid / ready | cmd, address, wdata0..wdata3
// rsp     | out       | valid / ready | hit, tag_out, line_out, offset_out, byte0..byte3
//
// A hit reads the tag and line, then updates them; a miss goes on to a fill
// state, since the victim write-back and the fill each go through the
// single port pair of the backing memory in one row-wide access.
// After reset the backing memory is cleared one row per cycle, covering all
// 2**(ADDR_BITS - log2(BLOCK_BYTES)) rows (65536 with the defaults); req.ready
// stays low meanwhile. A held response stalls completion of the next request,
// but the next request is still taken while the response waits.
`default_nettype none

module direct_mapped_writeback_cache
	import dmc_pkg::*;
#(
	parameter int unsigned NUM_LINES    = DefNumLines,
	parameter int unsigned BLOCK_BYTES  = DefBlockBytes,
	parameter int unsigned ADDR_BITS    = DefAddrBits,
	parameter int unsigned ACCESS_BYTES = DefAccessBytes
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dmc_req_if.sink    req,
	dmc_rsp_if.source  rsp
);

	localparam int unsigned LINE_BITS = $clog2(NUM_LINES);
	localparam int unsigned OFF_BITS  = $clog2(BLOCK_BYTES);
	localparam int unsigned TAG_BITS  = ADDR_BITS - LINE_BITS - OFF_BITS;
	// A backing memory row holds one whole block.
	localparam int unsigned ROW_BITS  = ADDR_BITS - OFF_BITS;
	localparam int unsigned ROW_W     = BLOCK_BYTES * BYTE_W;
	localparam int unsigned BACK_ROWS = 2 ** ROW_BITS;
	// A cache memory row holds the tag above the line's data.
	localparam int unsigned CROW_W    = TAG_BITS + ROW_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL
	} state_t;

	state_t state_q;

	// Control state.
	logic [ROW_BITS-1:0]  clr_cnt_q;
	logic [NUM_LINES-1:0] valid_q;
	logic [NUM_LINES-1:0] dirty_q;

	// Registered response.
	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	logic [TAG_BITS-1:0]  rsp_tag_q;
	logic [LINE_BITS-1:0] rsp_line_q;
	logic [OFF_BITS-1:0]  rsp_off_q;
	byte_t                rsp_byte_q [LANES];

	// Request being served.
	logic                 cmd_q;
	logic [ADDR_BITS-1:0] addr_q;
	byte_t                wdata_q [LANES];

	// Memories and their ports.
	logic [CROW_W-1:0]    cache_mem [NUM_LINES];
	logic [CROW_W-1:0]    crdata_q;
	logic                 c_re;
	logic                 c_we;
	logic [LINE_BITS-1:0] c_raddr;
	logic [CROW_W-1:0]    c_wdata;

	logic [ROW_W-1:0]     back_mem [BACK_ROWS];
	logic [ROW_W-1:0]     brdata_q;
	logic                 b_re;
	logic                 b_we;
	logic [ROW_BITS-1:0]  b_raddr;
	logic [ROW_BITS-1:0]  b_waddr;
	logic [ROW_W-1:0]     b_wdata;

	// Datapath.
	logic                 req_acc;
	logic [OFF_BITS-1:0]  off_c;
	logic [LINE_BITS-1:0] ln_c;
	logic [TAG_BITS-1:0]  tag_c;
	logic [TAG_BITS-1:0]  ctag_c;
	logic [ROW_W-1:0]     cdata_c;
	logic                 hit_c;
	logic                 out_free;
	logic                 res_load;
	logic [ROW_W-1:0]     src_row_c;
	logic [ROW_W-1:0]     new_row_c;
	logic [OFF_BITS-1:0]  lane_c [LANES];
	byte_t                res_byte_c [LANES];

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.tag_out    = rsp_tag_q;
	assign rsp.line_out   = rsp_line_q;
	assign rsp.offset_out = rsp_off_q;
	assign rsp.byte0      = rsp_byte_q[0];
	assign rsp.byte1      = rsp_byte_q[1];
	assign rsp.byte2      = rsp_byte_q[2];
	assign rsp.byte3      = rsp_byte_q[3];

	// The output register may be refilled when it is empty or being drained.
	assign out_free = !rsp_valid_q || rsp.ready;

	// Address fields of the request in flight.
	assign off_c = addr_q[OFF_BITS-1:0];
	assign ln_c  = addr_q[OFF_BITS +: LINE_BITS];
	assign tag_c = addr_q[ADDR_BITS-1 -: TAG_BITS];

	// Stored tag and data of the selected line, valid in the cycle after the read.
	assign ctag_c  = crdata_q[ROW_W +: TAG_BITS];
	assign cdata_c = crdata_q[ROW_W-1:0];
	assign hit_c   = valid_q[ln_c] && (ctag_c == tag_c);

	// A hit completes in the lookup cycle; a miss completes once the fill
	// data is back from the backing memory.
	assign res_load = out_free &&
		(((state_q == ST_LOOKUP) && hit_c) || (state_q == ST_FILL));

	// Line data that the access works on: the cached line on a hit, the
	// freshly read block on a fill.
	assign src_row_c = (state_q == ST_FILL) ? brdata_q : cdata_c;

	// Byte lanes wrap within the block. Lanes beyond the access width read
	// as zero and write nothing.
	always_comb begin
		new_row_c = src_row_c;
		for (int k = 0; k < LANES; k++) begin
			lane_c[k] = off_c + OFF_BITS'(k);
			if (k < ACCESS_BYTES) begin
				if (cmd_q == CMD_WRITE) begin
					res_byte_c[k] = wdata_q[k];
					new_row_c[lane_c[k]*BYTE_W +: BYTE_W] = wdata_q[k];
				end else begin
					res_byte_c[k] = src_row_c[lane_c[k]*BYTE_W +: BYTE_W];
				end
			end else begin
				res_byte_c[k] = '0;
			end
		end
	end

	// Cache memory: read the line as the request is taken, write it back
	// when a write hits or when a fill completes.
	assign c_re    = req_acc;
	assign c_raddr = req.address[OFF_BITS +: LINE_BITS];
	assign c_we    = res_load && ((state_q == ST_FILL) || (cmd_q == CMD_WRITE));
	assign c_wdata = {tag_c, new_row_c};

	// Backing memory: the clearing pass after reset, then the victim
	// write-back and the fill read, issued together in the lookup cycle of a
	// miss. Their rows always differ since the tags differ.
	always_comb begin
		b_re    = (state_q == ST_LOOKUP) && !hit_c;
		b_raddr = {tag_c, ln_c};
		if (state_q == ST_CLEAR) begin
			b_we    = 1'b1;
			b_waddr = clr_cnt_q;
			b_wdata = '0;
		end else begin
			b_we    = (state_q == ST_LOOKUP) && !hit_c && valid_q[ln_c] && dirty_q[ln_c];
			b_waddr = {ctag_c, ln_c};
			b_wdata = cdata_c;
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			cache_mem[ln_c] <= c_wdata;
		end
		if (c_re) begin
			crdata_q <= cache_mem[c_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			back_mem[b_waddr] <= b_wdata;
		end
		if (b_re) begin
			brdata_q <= back_mem[b_raddr];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q      <= req.cmd;
			addr_q     <= req.address;
			wdata_q[0] <= req.wdata0;
			wdata_q[1] <= req.wdata1;
			wdata_q[2] <= req.wdata2;
			wdata_q[3] <= req.wdata3;
		end
	end

	// Sequencer, line status and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			valid_q     <= '0;
			dirty_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_tag_q   <= '0;
			rsp_line_q  <= '0;
			rsp_off_q   <= '0;
			for (int k = 0; k < LANES; k++) begin
				rsp_byte_q[k] <= '0;
			end
		end else begin
			if (res_load) begin
				rsp_valid_q <= 1'b1;
				rsp_hit_q   <= (state_q == ST_LOOKUP);
				rsp_tag_q   <= tag_c;
				rsp_line_q  <= ln_c;
				rsp_off_q   <= off_c;
				for (int k = 0; k < LANES; k++) begin
					rsp_byte_q[k] <= res_byte_c[k];
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (!hit_c) begin
						state_q <= ST_FILL;
					end else if (out_free) begin
						if (cmd_q == CMD_WRITE) begin
							dirty_q[ln_c] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (out_free) begin
						valid_q[ln_c] <= 1'b1;
						dirty_q[ln_c] <= (cmd_q == CMD_WRITE);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// No request is taken while the backing memory is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request taken during clearing pass");

	// Only a valid line can be dirty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q) == '0)
		else $error("dirty mark on an invalid line");

	// Write-back and fill never address the same row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(b_we && b_re) |-> (b_waddr != b_raddr))
		else $error("write-back and fill collide");

	// A completed hit shows up as a hit response.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOOKUP) && hit_c && out_free) |=> (rsp.valid && rsp.hit))
		else $error("hit not reported");

	// A completed fill is reported as a miss and leaves its line valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FILL) && out_free) |=>
		(rsp.valid && !rsp.hit && valid_q[rsp.line_out]))
		else $error("fill not completed");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import dmc_pkg::*;

	// Geometry of the cache under test, taken from the package defaults.
	localparam int unsigned NUM_LINES    = DefNumLines;
	localparam int unsigned BLOCK_BYTES  = DefBlockBytes;
	localparam int unsigned ADDR_BITS    = DefAddrBits;
	localparam int unsigned ACCESS_BYTES = DefAccessBytes;
	localparam int unsigned LINE_BITS    = $clog2(NUM_LINES);
	localparam int unsigned OFF_BITS     = $clog2(BLOCK_BYTES);
	localparam int unsigned TAG_BITS     = ADDR_BITS - LINE_BITS - OFF_BITS;

	// Run shape. The backing memory is cleared one row per cycle after reset, all 65536
	// rows with req.ready low, so the watchdog limit is set well above that pass.
	localparam int unsigned MAX_GAP         = 17;
	localparam int unsigned RANDOM_REQUESTS = 1250;
	localparam int unsigned BURST_SPAN      = 50;
	localparam int unsigned HOLD_OFF_AT     = 300;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES    = 40;
	localparam int unsigned WATCHDOG_LIMIT  = 250000;
	localparam int unsigned DIRECTED_ROWS   = 20;
	localparam int unsigned TAG_POOL_SIZE   = 4;

	// One row of the directed table. When pinned is set, the expected hit flag and
	// data bytes are typed in the row; the address fields follow from the address.
	typedef struct packed {
		logic                 cmd;
		logic [ADDR_BITS-1:0] address;
		byte_t [0:3]          wdata;
		bit                   pinned;
		logic                 exp_hit;
		byte_t [0:3]          exp_data;
	} directed_row_t;

	// What one response of the cache carries.
	typedef struct packed {
		logic                 hit;
		logic [TAG_BITS-1:0]  tag;
		logic [LINE_BITS-1:0] line;
		logic [OFF_BITS-1:0]  offset;
		byte_t [0:3]          data;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dmc_req_if #(.ADDR_BITS(ADDR_BITS)) req ();
	dmc_rsp_if #(.ADDR_BITS(ADDR_BITS), .NUM_LINES(NUM_LINES), .BLOCK_BYTES(BLOCK_BYTES)) rsp ();

	direct_mapped_writeback_cache #(
		.NUM_LINES   (NUM_LINES),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (ADDR_BITS),
		.ACCESS_BYTES(ACCESS_BYTES)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	// Shadow copy of the cache: valid, dirty and tag per line, the line bytes, and
	// a sparse image of the backing memory in which absent bytes read as zero.
	bit                cache_valid [NUM_LINES];
	bit                cache_dirty [NUM_LINES];
	bit [TAG_BITS-1:0] cache_tag   [NUM_LINES];
	bit [7:0]          cache_data  [NUM_LINES][BLOCK_BYTES];
	byte_t             memory_image [int unsigned];

	// Results still owed by the cache, oldest first.
	access_result_t expected_results [$];
	int unsigned    failures = 0;
	bit             send_burst = 1'b0;

	// The directed table. It starts from the cleared state, then exercises a write
	// whose lanes wrap around the end of the block, the top address with all-ones
	// data, a dirty eviction followed by a refill that must return the written bytes,
	// and conflicting tags on one line.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Cold read after reset: a miss that fills zeros.
		'{CMD_READ,  20'h00000, 32'h00000000, 1'b1, 1'b0, 32'h00000000},
		// The same block again is a hit.
		'{CMD_READ,  20'h00000, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
		// Write at offset 13: lanes 13, 14, 15 and then 0 of the same block.
		'{CMD_WRITE, 20'h0000D, 32'h11223344, 1'b1, 1'b1, 32'h11223344},
		'{CMD_READ,  20'h0000D, 32'h00000000, 1'b1, 1'b1, 32'h11223344},
		'{CMD_READ,  20'h00000, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		// Highest address: tag, line and offset all at their maximum.
		'{CMD_READ,  20'hFFFFF, 32'h00000000, 1'b1, 1'b0, 32'h00000000},
		'{CMD_WRITE, 20'hFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF},
		'{CMD_READ,  20'hFFFFC, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		// Tag 1 on line 0 evicts the dirty block, then tag 0 brings it back.
		'{CMD_READ,  20'h00080, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'h0000D, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_WRITE, 20'h7FF8E, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'h7FF8E, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		// Line 7 with another tag evicts the all-ones block, which is then reloaded.
		'{CMD_READ,  20'hFFF7F, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'hFFFF0, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_WRITE, 20'h12345, 32'hA55AC33C, 1'b0, 1'b0, 32'h00000000},
		'{CMD_WRITE, 20'h12345, 32'hFF00FF00, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'h1234F, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'h02345, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_READ,  20'h12345, 32'h00000000, 1'b0, 1'b0, 32'h00000000},
		'{CMD_WRITE, 20'h0000C, 32'h01020304, 1'b0, 1'b0, 32'h00000000}
	};

	// Applies one access to the shadow cache and returns the response it must give.
	function automatic access_result_t predict_access(input logic cmd,
			input logic [ADDR_BITS-1:0] address, input byte_t [0:3] wdata);
		access_result_t       result;
		logic [OFF_BITS-1:0]  offset;
		logic [LINE_BITS-1:0] line;
		logic [TAG_BITS-1:0]  tag;
		logic [ADDR_BITS-1:0] base;
		logic [OFF_BITS-1:0]  lane;
		int unsigned          a;
		int unsigned          k;
		offset = address[OFF_BITS-1:0];
		line   = address[OFF_BITS +: LINE_BITS];
		tag    = address[ADDR_BITS-1 -: TAG_BITS];
		result.hit = cache_valid[line] && (cache_tag[line] == tag);
		if (!result.hit) begin
			// A dirty victim goes back to memory before the new block is fetched.
			if (cache_valid[line] && cache_dirty[line]) begin
				base = {cache_tag[line], line, {OFF_BITS{1'b0}}};
				for (a = 0; a < BLOCK_BYTES; a++)
					memory_image[base + a] = cache_data[line][a];
			end
			base = {tag, line, {OFF_BITS{1'b0}}};
			for (a = 0; a < BLOCK_BYTES; a++)
				cache_data[line][a] = memory_image.exists(base + a) ? memory_image[base + a] : 8'h00;
			cache_dirty[line] = 1'b0;
			cache_tag[line]   = tag;
			cache_valid[line] = 1'b1;
		end
		result.tag    = tag;
		result.line   = line;
		result.offset = offset;
		for (k = 0; k < LANES; k++) begin
			// The lane index wraps at the block size, never into the next block.
			lane = offset + k[OFF_BITS-1:0];
			result.data[k] = 8'h00;
			if (k < ACCESS_BYTES) begin
				if (cmd == CMD_WRITE) begin
					cache_data[line][lane] = wdata[k];
					result.data[k] = wdata[k];
				end else begin
					result.data[k] = cache_data[line][lane];
				end
			end
		end
		if (cmd == CMD_WRITE)
			cache_dirty[line] = 1'b1;
		return result;
	endfunction

	// Offers one request after a random gap and, once it is taken, records the
	// response it must produce. A pinned result replaces the predicted one.
	task automatic send_request(input logic cmd, input logic [ADDR_BITS-1:0] address,
			input byte_t [0:3] wdata, input bit pinned, input access_result_t pinned_result);
		int unsigned    gap;
		access_result_t predicted;
		access_result_t owed;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.cmd     <= cmd;
		req.address <= address;
		req.wdata0  <= wdata[0];
		req.wdata1  <= wdata[1];
		req.wdata2  <= wdata[2];
		req.wdata3  <= wdata[3];
		do @(posedge clk); while (req.ready !== 1'b1);
		predicted = predict_access(cmd, address, wdata);
		owed = pinned ? pinned_result : predicted;
		expected_results.insert(expected_results.size(), owed);
	endtask

	task automatic check_field(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 'h%0h, actual 'h%0h", field, want, got);
			failures++;
		end
	endtask

	// Request side: reset, the directed table, then random accesses. Most random
	// addresses use a small pool of tags so that hits, conflicts and dirty
	// evictions are frequent; the rest are spread over the whole address space.
	initial begin
		access_result_t       pinned_result;
		logic [TAG_BITS-1:0]  tag_pool [TAG_POOL_SIZE];
		logic [TAG_BITS-1:0]  tag;
		logic [ADDR_BITS-1:0] address;
		logic                 cmd;
		int unsigned          i;
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.cmd     <= CMD_READ;
		req.address <= '0;
		req.wdata0  <= '0;
		req.wdata1  <= '0;
		req.wdata2  <= '0;
		req.wdata3  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			pinned_result.hit    = directed_rows[i].exp_hit;
			pinned_result.tag    = directed_rows[i].address[ADDR_BITS-1 -: TAG_BITS];
			pinned_result.line   = directed_rows[i].address[OFF_BITS +: LINE_BITS];
			pinned_result.offset = directed_rows[i].address[OFF_BITS-1:0];
			pinned_result.data   = directed_rows[i].exp_data;
			send_request(directed_rows[i].cmd, directed_rows[i].address,
				directed_rows[i].wdata, directed_rows[i].pinned, pinned_result);
		end

		tag_pool[0] = '0;
		tag_pool[1] = '1;
		tag_pool[2] = TAG_BITS'($urandom);
		tag_pool[3] = TAG_BITS'($urandom);
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			// Now and then the sender runs a stretch without any gaps.
			if (i % BURST_SPAN == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85) begin
				tag = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
				address = {tag, LINE_BITS'($urandom), OFF_BITS'($urandom)};
			end else begin
				address = ADDR_BITS'($urandom);
			end
			cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			send_request(cmd, address, $urandom, 1'b0, '0);
		end
		req.valid <= 1'b0;

		// Wait for every owed response, then a little longer for stray ones.
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Response side: a random stall before each response, stretches without stalls,
	// and once a long hold-off so that the cache holds its response and stalls its requests.
	initial begin
		access_result_t want;
		access_result_t got;
		int unsigned    stall;
		int unsigned    count;
		bit             burst;
		int unsigned    k;
		rsp.ready <= 1'b0;
		count = 0;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (count % BURST_SPAN == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (count == HOLD_OFF_AT)
				stall = HOLD_OFF_CYCLES;
			else
				stall = burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
			got.hit     = rsp.hit;
			got.tag     = rsp.tag_out;
			got.line    = rsp.line_out;
			got.offset  = rsp.offset_out;
			got.data[0] = rsp.byte0;
			got.data[1] = rsp.byte1;
			got.data[2] = rsp.byte2;
			got.data[3] = rsp.byte3;
			count++;
			if (expected_results.size() == 0) begin
				$error("response arrived with no request outstanding");
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("hit", want.hit, got.hit);
				check_field("tag_out", want.tag, got.tag);
				check_field("line_out", want.line, got.line);
				check_field("offset_out", want.offset, got.offset);
				for (k = 0; k < LANES; k++)
					check_field($sformatf("byte%0d", k), want.data[k], got.data[k]);
			end
		end
	end

	// The watchdog ends the run when no request or response has moved for too long.
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) === 1'b1 || (rsp.valid && rsp.ready) === 1'b1)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench failed");
		$finish;
	end

endmodule
